// ----- design/deq_pkg.sv -----
// Shared types and codes for the double-ended queue.
// Depends on nothing; every other design file imports it.
package deq_pkg;

   localparam int WORD_W = 32;
   localparam int OCC_W  = 5;

   typedef logic [1:0]               cmd_type;
   typedef logic [1:0]               status_type;
   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [OCC_W-1:0]         occ_type;

   // Command codes carried by a request.
   localparam cmd_type CMD_PUSH_FRONT = 2'd0;
   localparam cmd_type CMD_PUSH_REAR  = 2'd1;
   localparam cmd_type CMD_POP_FRONT  = 2'd2;
   localparam cmd_type CMD_POP_REAR   = 2'd3;

   // Status codes returned with every response.
   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_EMPTY = 2'd1;
   localparam status_type STAT_FULL  = 2'd2;

   // Word returned for every push and for a pop on an empty queue.
   localparam word_type NO_VALUE = -32'sd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the request payload
      logic exec;   // perform the operation on the ring store
   } ctrl_type;

endpackage

// ----- design/deq_req_if.sv -----
// Request channel: valid/ready handshake carrying one queue command.
// Depends on deq_pkg.
interface deq_req_if import deq_pkg::*; ();
   logic     valid;
   logic     ready;
   cmd_type  cmd;
   word_type push_value;

   modport source (output valid, output cmd, output push_value, input ready);
   modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

// ----- design/deq_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one queue result.
// Depends on deq_pkg.
interface deq_rsp_if import deq_pkg::*; ();
   logic       valid;
   logic       ready;
   word_type   pop_value;
   status_type status;
   occ_type    occupancy;

   modport source (output valid, output pop_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input pop_value, input status, input occupancy,
                   output ready);
endinterface

// ----- design/deq_ctrl.sv -----
// Controller state machine of the double-ended queue: handshakes and sequencing.
// Depends on deq_pkg.
module deq_ctrl import deq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output ctrl_type ctrl
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign ctrl.load = req_valid && (state_ff == S_IDLE);
   assign ctrl.exec = (state_ff == S_EXEC);

endmodule

// ----- design/deq_dpath.sv -----
// Datapath of the double-ended queue: ring store, indices, count and result registers.
// Depends on deq_pkg; driven by deq_ctrl through ctrl_type.
module deq_dpath import deq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  ctrl_type   ctrl,
   input  cmd_type    cmd,
   input  word_type   push_value,
   output word_type   pop_value,
   output status_type status,
   output occ_type    occupancy
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   word_type mem [DEPTH];

   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type          cmd_ff;
   word_type         push_ff;
   word_type         rd_data_ff;
   logic             popped_ff, popped_in;
   status_type       status_ff, status_in;

   logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic             wr_en, rd_en, is_full, is_empty;
   logic [CNT_W+OCC_W-1:0] occ_wide;

   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;
   assign is_full  = (count_ff == FULL_CNT);
   assign is_empty = (count_ff == '0);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      popped_in = 1'b0;
      status_in = STAT_OK;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = tail_ff;
      rd_addr   = head_ff;
      unique case (cmd_ff)
         CMD_PUSH_FRONT: begin
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               head_in  = head_dec;
               wr_addr  = head_dec;
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_PUSH_REAR: begin
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               wr_addr  = tail_ff;
               tail_in  = tail_inc;
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (is_empty) begin
               status_in = STAT_EMPTY;
            end else begin
               rd_addr   = head_ff;
               head_in   = head_inc;
               rd_en     = 1'b1;
               popped_in = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         CMD_POP_REAR: begin
            if (is_empty) begin
               status_in = STAT_EMPTY;
            end else begin
               tail_in   = tail_dec;
               rd_addr   = tail_dec;
               rd_en     = 1'b1;
               popped_in = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   // Ring store: one write or one registered read per operation.
   always_ff @(posedge clock) begin
      if (ctrl.exec && wr_en) mem[wr_addr] <= push_ff;
      if (ctrl.exec && rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff  <= cmd;
         push_ff <= push_value;
      end
      if (ctrl.exec) begin
         popped_ff <= popped_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (ctrl.exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign occ_wide  = {{OCC_W{1'b0}}, count_ff};
   assign occupancy = occ_wide[OCC_W-1:0];
   assign pop_value = popped_ff ? rd_data_ff : NO_VALUE;
   assign status    = status_ff;

endmodule

// ----- design/double_ended_queue.sv -----
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on deq_pkg, deq_req_if, deq_rsp_if, deq_ctrl and deq_dpath.
//
//   Channel    Direction  Carries
//   req_chan   in         cmd, push_value
//   rsp_chan   out        pop_value, status, occupancy
//
// A request is captured in the idle state at its transfer, the execute state then runs it
// against the ring store with its registered read port, and the response is offered from
// the response state that follows. A new request is accepted only after the response
// transfer has returned the block to the idle state.
// Reset clears the head index, the tail index and the entry count; the ring
// store is not cleared, since only entries that were written are ever read.
// A stalled response holds its values and blocks the next request until the
// response transfer completes.
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic         clock,
   input logic         reset,
   deq_req_if.sink     req_chan,
   deq_rsp_if.source   rsp_chan
);

   ctrl_type ctrl;

   // The controller owns both handshakes and tells the datapath when to
   // capture a request and when to run it against the ring store.
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .ctrl      (ctrl)
   );

   // The datapath keeps the ring store, both indices and the entry count, and
   // holds the result of the last operation until the response transfer.
   deq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .cmd        (req_chan.cmd),
      .push_value (req_chan.push_value),
      .pop_value  (rsp_chan.pop_value),
      .status     (rsp_chan.status),
      .occupancy  (rsp_chan.occupancy)
   );

endmodule

// ----- design/deq_checker.sv -----
// Port-level checks for the double-ended queue, attached by a bind below.
// Depends on deq_pkg and double_ended_queue.
module deq_checker import deq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input word_type   pop_value,
   input status_type status,
   input occ_type    occupancy
);

   localparam occ_type FULL_OCC = OCC_W'(DEPTH);

   // An offered response stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // Every request transfer yields an offered response after the execute state.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("response missing after request transfer");

   // No request is taken while a response is pending.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while response pending");

   // A pop on an empty queue returns the no-value word and zero occupancy.
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STAT_EMPTY |-> pop_value == NO_VALUE && occupancy == '0)
      else $error("empty pop reported wrong value or occupancy");

   // A push on a full queue reports a full occupancy and the no-value word.
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STAT_FULL |-> occupancy == FULL_OCC && pop_value == NO_VALUE)
      else $error("full push reported wrong occupancy");

endmodule

bind double_ended_queue deq_checker #(
   .DEPTH (DEPTH)
) u_deq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .pop_value (rsp_chan.pop_value),
   .status    (rsp_chan.status),
   .occupancy (rsp_chan.occupancy)
);

// ----- test/double_ended_queue_test.sv -----
// Self-checking testbench for double_ended_queue with a built-in deque predictor.
// Depends on deq_pkg, deq_req_if, deq_rsp_if and the double_ended_queue design files.
module double_ended_queue_test;
   import deq_pkg::*;

   localparam int DEPTH = 16;

   // With its response taken at once, a request occupies idle, execute and response.
   localparam int RESPONSE_LATENCY = 3;

   // A response as the predictor expects it.
   typedef struct packed {
      word_type   pop_value;
      status_type status;
      occ_type    occupancy;
   } deq_result_type;

   logic clock;
   logic reset = 1'b1;

   deq_req_if req_chan ();
   deq_rsp_if rsp_chan ();

   double_ended_queue #(.DEPTH(DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Mirror of the deque state that the predictor keeps. The front index names the front
   // entry and the rear index the free slot just past the rear entry.
   word_type mirror_store [DEPTH];
   int       front_index = 0;
   int       rear_index  = 0;
   int       held_count  = 0;

   // Responses still owed by the block, oldest first.
   deq_result_type expected_results [$];
   deq_result_type oldest_result;
   int             mismatch_count = 0;

   // Idle control. Each side draws its wait from 0 to its maximum; a maximum of zero gives a
   // stretch with no idling at all. A nonzero long hold makes the receiver keep ready low
   // for that many cycles the next time it draws.
   int sender_gap_max    = 16;
   int receiver_gap_max  = 16;
   int long_hold_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one command to the mirror state and returns the response it must cause. Pushes
   // and empty pops always report the no-value word.
   function automatic deq_result_type apply_deque_op(input cmd_type op, input word_type value);
      deq_result_type result;
      result.pop_value = NO_VALUE;
      result.status    = STAT_OK;
      case (op)
         CMD_PUSH_FRONT: begin
            if (held_count >= DEPTH) begin
               result.status = STAT_FULL;
            end else begin
               front_index = (front_index == 0) ? DEPTH - 1 : front_index - 1;
               mirror_store[front_index] = value;
               held_count++;
            end
         end
         CMD_PUSH_REAR: begin
            if (held_count >= DEPTH) begin
               result.status = STAT_FULL;
            end else begin
               mirror_store[rear_index] = value;
               rear_index = (rear_index + 1 >= DEPTH) ? 0 : rear_index + 1;
               held_count++;
            end
         end
         CMD_POP_FRONT: begin
            if (held_count == 0) begin
               result.status = STAT_EMPTY;
            end else begin
               result.pop_value = mirror_store[front_index];
               front_index = (front_index + 1 >= DEPTH) ? 0 : front_index + 1;
               held_count--;
            end
         end
         CMD_POP_REAR: begin
            if (held_count == 0) begin
               result.status = STAT_EMPTY;
            end else begin
               rear_index = (rear_index == 0) ? DEPTH - 1 : rear_index - 1;
               result.pop_value = mirror_store[rear_index];
               held_count--;
            end
         end
      endcase
      result.occupancy = occ_type'(held_count);
      return result;
   endfunction

   // Picks a word for a push: often fully random, sometimes an extreme, -1 or a small value.
   function automatic word_type pick_word();
      case ($urandom_range(7, 0))
         0: return 32'sh7FFF_FFFF;
         1: return -32'sh8000_0000;
         2: return NO_VALUE;
         3: return word_type'($urandom_range(3, 0));
         default: return word_type'($urandom);
      endcase
   endfunction

   // Offers one request after a random gap and returns at the edge of its transfer. When
   // the gap is zero, valid simply stays high from the previous transfer.
   task automatic send_deque_op(input cmd_type op, input word_type value);
      int gap;
      gap = (sender_gap_max == 0) ? 0 : $urandom_range(sender_gap_max, 0);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= op;
      req_chan.push_value <= value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // Pops on a freshly reset queue must report empty from both ends.
   task automatic test_empty_pops();
      send_deque_op(CMD_POP_FRONT, 32'sh1234_5678);
      send_deque_op(CMD_POP_REAR, -32'sh8000_0000);
   endtask

   // The first word pushed is both front and rear, so it comes back from the other end.
   task automatic test_first_insert();
      send_deque_op(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
      send_deque_op(CMD_POP_REAR, '0);
      send_deque_op(CMD_PUSH_REAR, -32'sh8000_0000);
      send_deque_op(CMD_POP_FRONT, '0);
   endtask

   // Fills the queue from both ends, which wraps the front index below zero, and then
   // tries one push at each end on the full queue; both must be dropped.
   task automatic test_fill_to_full();
      for (int i = 0; i < DEPTH; i++) begin
         send_deque_op(i[0] ? CMD_PUSH_REAR : CMD_PUSH_FRONT,
                       word_type'({8{i[3:0]}}));
      end
      send_deque_op(CMD_PUSH_FRONT, 32'sd123);
      send_deque_op(CMD_PUSH_REAR, -32'sd5);
   endtask

   // The receiver holds ready low for a long stretch while the sender offers back to back,
   // so a response stays pending and the block has to stall its request channel.
   task automatic test_backpressure();
      sender_gap_max   = 0;
      long_hold_cycles = 300;
      for (int i = 0; i < 40; i++) begin
         send_deque_op(cmd_type'($urandom_range(3, 0)), pick_word());
      end
      sender_gap_max = 16;
   endtask

   // Bursts of random commands. Each burst draws its own push share, often leaning toward
   // pushes or pops, so the occupancy sweeps between empty and full, with both ends and both
   // index wraps exercised. Idling is switched per burst, so some bursts run with no gaps at all.
   task automatic test_random_mix();
      int sent;
      int burst_len;
      int push_pct;
      cmd_type op;
      sent = 0;
      while (sent < 1880) begin
         burst_len = $urandom_range(60, 20);
         case ($urandom_range(3, 0))
            0: push_pct = 15;
            1: push_pct = 50;
            2: push_pct = 85;
            default: push_pct = $urandom_range(100, 0);
         endcase
         sender_gap_max   = ($urandom_range(3, 0) == 0) ? 0 : 16;
         receiver_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 16;
         for (int i = 0; i < burst_len; i++) begin
            if ($urandom_range(99, 0) < push_pct) begin
               op = $urandom_range(1, 0) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
            end else begin
               op = $urandom_range(1, 0) ? CMD_POP_REAR : CMD_POP_FRONT;
            end
            send_deque_op(op, pick_word());
            sent++;
         end
      end
      sender_gap_max   = 16;
      receiver_gap_max = 16;
   endtask

   initial begin
      req_chan.valid      <= 1'b0;
      req_chan.cmd        <= CMD_PUSH_FRONT;
      req_chan.push_value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_pops();
      test_first_insert();
      test_fill_to_full();
      test_backpressure();
      test_random_mix();

      // The last request has transferred; nothing more is offered.
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      // A final wait catches any response the block should not have produced.
      repeat (4 * RESPONSE_LATENCY + 10) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Response ready. Each response gets its own random hold-off, or the long hold when one
   // has been asked for.
   initial begin
      int hold;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_cycles > 0) begin
            hold = long_hold_cycles;
            long_hold_cycles = 0;
         end else begin
            hold = (receiver_gap_max == 0) ? 0 : $urandom_range(receiver_gap_max, 0);
         end
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // Request transfers feed the predictor and response transfers are checked against the
   // oldest expectation. Both are seen at the same edge so their order is fixed here.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            expected_results.push_back(apply_deque_op(req_chan.cmd, req_chan.push_value));
         end
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0d/%0d/%0d",
                        $time, rsp_chan.pop_value, rsp_chan.status, rsp_chan.occupancy);
               mismatch_count++;
            end else begin
               oldest_result = expected_results.pop_front();
               if (rsp_chan.pop_value !== oldest_result.pop_value) begin
                  $display("%0t: pop_value expected %0d, actual %0d",
                           $time, oldest_result.pop_value, rsp_chan.pop_value);
                  mismatch_count++;
               end
               if (rsp_chan.status !== oldest_result.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, oldest_result.status, rsp_chan.status);
                  mismatch_count++;
               end
               if (rsp_chan.occupancy !== oldest_result.occupancy) begin
                  $display("%0t: occupancy expected %0d, actual %0d",
                           $time, oldest_result.occupancy, rsp_chan.occupancy);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Run limit, several times the slowest correct run.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
